// ----- rtl/core/huf_pkg.sv -----
// Shared types and constants of the stream decoder.
`timescale 1ns / 1ps
package huf_pkg;

    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam int         DIGITS   = 10;
    localparam logic [2:0] BIT_TOP  = 3'd7;

    localparam logic [1:0] ST_SYMBOL     = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_OVERFLOW   = 2'd2;

    typedef struct packed {
        logic is_digit;
        logic is_comma;
        logic is_one;
    } t_kind;

    typedef struct packed {
        logic [7:0] symbol;
        logic       run_end;
        logic       done_res;
        logic [1:0] status;
    } t_result;

endpackage

// ----- rtl/core/huffman_stream_decoder.sv -----
// Top level of the pre-order serialized Huffman stream decoder.
// Input channel: one stream byte per beat, pushed with i_push while o_full is low.
// Result channel: a queue; while o_empty is low the oldest result is on the ports
// and i_pop takes it. o_run_end marks the last result caused by one input byte.
// A two-entry input queue and a four-entry result queue let the sides stall apart.
// For a code byte the tree walk does one node-memory read per code bit, eight bits
// per byte, after fetch and dispatch and before a final flush.
// Each result is held in a pending register so that the run end mark can be set on the last one.
// Reset is synchronous and active low; it returns the decoder to the header phase
// and empties both queues. Node and stack memories are not cleared.
// When the receiver stalls the result queue fills, the engine waits, and then the
// input queue fills and o_full rises.
`timescale 1ns / 1ps
module huffman_stream_decoder #(
    parameter int NODE_DEPTH  = 512,
    parameter int STACK_DEPTH = 256,
    parameter int COUNT_BITS  = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_byte,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_symbol,
    output logic       o_run_end,
    output logic       o_done_res,
    output logic [1:0] o_status
);
    import huf_pkg::*;

    logic       w_avail;
    logic [7:0] w_byte;
    t_kind      w_kind;
    logic       w_take;
    logic       w_res_push;
    t_result    w_res_in;
    logic       w_res_full;
    t_result    w_res_out;

    huf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_in_byte (i_in_byte),
        .o_avail   (w_avail),
        .o_byte    (w_byte),
        .o_kind    (w_kind),
        .i_take    (w_take)
    );

    huf_engine #(
        .NODE_DEPTH  (NODE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (w_avail),
        .i_byte     (w_byte),
        .i_kind     (w_kind),
        .o_take     (w_take),
        .o_res_push (w_res_push),
        .o_res      (w_res_in),
        .i_res_full (w_res_full)
    );

    huf_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .o_empty (o_empty),
        .o_res   (w_res_out),
        .i_pop   (i_pop)
    );

    assign o_symbol   = w_res_out.symbol;
    assign o_run_end  = w_res_out.run_end;
    assign o_done_res = w_res_out.done_res;
    assign o_status   = w_res_out.status;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("Engine wrote a result beat into a full result queue.");

    a_take_only_when_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_avail)
        else $error("Engine took a byte from an empty input queue.");

    a_error_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_status != ST_SYMBOL)) |-> (o_symbol == 8'd0) && !o_done_res
        && o_run_end)
        else $error("An error result carries a symbol, a done mark or no run end.");

endmodule

// ----- rtl/core/huf_front.sv -----
// Input side: accepts stream bytes, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module huf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [7:0]     i_in_byte,
    output logic           o_avail,
    output logic [7:0]     o_byte,
    output huf_pkg::t_kind o_kind,
    input  logic           i_take
);
    import huf_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_entry;

    t_entry     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    t_entry     w_new;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_new.data          = i_in_byte;
        w_new.kind.is_one   = (i_in_byte == CH_ONE);
        w_new.kind.is_comma = (i_in_byte == CH_COMMA);
        w_new.kind.is_digit = (i_in_byte >= CH_ZERO) && (i_in_byte < CH_ZERO + 8'(DIGITS));
    end

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_byte  = r_mem[r_rptr].data;
    assign o_kind  = r_mem[r_rptr].kind;
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_new;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// ----- rtl/core/huf_out_fifo.sv -----
// Result queue between the engine and the result port.
`timescale 1ns / 1ps
module huf_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  huf_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    output huf_pkg::t_result o_res,
    input  logic             i_pop
);
    import huf_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [2:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_res   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_res;
        end
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 2'd1;
            end
            r_count <= r_count + {2'b0, w_wr} - {2'b0, w_rd};
        end
    end

endmodule

// ----- rtl/core/huf_engine.sv -----
// Decode engine: header count, tree build with node and stack memories, tree walk.
`timescale 1ns / 1ps
module huf_engine #(
    parameter int NODE_DEPTH  = 512,
    parameter int STACK_DEPTH = 256,
    parameter int COUNT_BITS  = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  logic [7:0]       i_byte,
    input  huf_pkg::t_kind   i_kind,
    output logic             o_take,
    output logic             o_res_push,
    output huf_pkg::t_result o_res,
    input  logic             i_res_full
);
    import huf_pkg::*;

    localparam int NW = $clog2(NODE_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_FETCH, S_EXEC, S_LINK, S_PUSH, S_RELOAD, S_DBIT, S_DCHK, S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        PH_HEADER, PH_TREE, PH_SEP, PH_DECODE, PH_DONE
    } t_phase;

    logic [8:0]    m_sym   [NODE_DEPTH];
    logic [NW-1:0] m_left  [NODE_DEPTH];
    logic [NW-1:0] m_right [NODE_DEPTH];
    logic [NW:0]   m_stack [STACK_DEPTH];

    logic [8:0]    r_sym_q;
    logic [NW-1:0] r_left_q;
    logic [NW-1:0] r_right_q;
    logic [NW:0]   r_stk_q;

    t_state          r_state,    n_state;
    t_phase          r_phase,    n_phase;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [NW:0]     r_next,     n_next;
    logic [SW:0]     r_top,      n_top;
    logic            r_leaf_exp, n_leaf_exp;
    logic [NW-1:0]   r_walk,     n_walk;
    logic [7:0]      r_byte,     n_byte;
    t_kind           r_kind,     n_kind;
    logic            r_is_leaf,  n_is_leaf;
    logic            r_popped,   n_popped;
    logic [NW-1:0]   r_cache_idx, n_cache_idx;
    logic            r_cache_ld, n_cache_ld;
    logic [2:0]      r_bit,      n_bit;
    logic            r_pend_v,   n_pend_v;
    t_result         r_pend,     n_pend;

    logic          w_can_emit;
    logic          w_emit;
    t_result       w_emit_val;
    logic          w_flush;
    logic [NW-1:0] w_nd_addr;
    logic          w_nd_we;
    logic [8:0]    w_nd_sym;
    logic          w_left_we;
    logic          w_right_we;
    logic          w_stk_we;
    logic [SW-1:0] w_stk_waddr;
    logic [NW:0]   w_stk_wdata;
    logic [SW-1:0] w_stk_raddr;
    logic          w_is_leaf;
    logic          w_will_pop;
    logic [SW:0]   w_eff;
    logic [NW-1:0] w_child;

    assign w_can_emit  = !r_pend_v || !i_res_full;
    assign w_stk_raddr = SW'(r_top - 1'b1);
    assign w_is_leaf   = r_leaf_exp;
    assign w_will_pop  = (r_top != '0) && r_cache_ld;
    assign w_eff       = r_top - {{SW{1'b0}}, w_will_pop};
    assign w_child     = r_byte[r_bit] ? r_right_q : r_left_q;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_next      = r_next;
        n_top       = r_top;
        n_leaf_exp  = r_leaf_exp;
        n_walk      = r_walk;
        n_byte      = r_byte;
        n_kind      = r_kind;
        n_is_leaf   = r_is_leaf;
        n_popped    = r_popped;
        n_cache_idx = r_cache_idx;
        n_cache_ld  = r_cache_ld;
        n_bit       = r_bit;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        o_take      = 1'b0;
        w_emit      = 1'b0;
        w_emit_val  = '0;
        w_flush     = 1'b0;
        w_nd_addr   = r_walk;
        w_nd_we     = 1'b0;
        w_nd_sym    = '0;
        w_left_we   = 1'b0;
        w_right_we  = 1'b0;
        w_stk_we    = 1'b0;
        w_stk_waddr = w_stk_raddr;
        w_stk_wdata = '0;

        case (r_state)
            S_FETCH: begin
                o_take = i_avail;
                if (i_avail) begin
                    n_byte  = i_byte;
                    n_kind  = i_kind;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_kind.is_comma) begin
                            n_phase    = PH_TREE;
                            n_top      = '0;
                            n_next     = '0;
                            n_leaf_exp = 1'b0;
                            n_walk     = '0;
                            n_state    = S_FETCH;
                        end else if (r_kind.is_digit) begin
                            n_rem   = (r_rem << 3) + (r_rem << 1)
                                    + COUNT_BITS'(r_byte - CH_ZERO);
                            n_state = S_FETCH;
                        end else if (w_can_emit) begin
                            w_emit            = 1'b1;
                            w_emit_val.status = ST_BAD_HEADER;
                            n_state           = S_FLUSH;
                        end
                    end
                    PH_TREE: begin
                        if (!r_leaf_exp && r_kind.is_one) begin
                            n_leaf_exp = 1'b1;
                            n_state    = S_FETCH;
                        end else if ((r_next >= (NW+1)'(NODE_DEPTH))
                                || (!w_is_leaf && (w_eff >= (SW+1)'(STACK_DEPTH)))) begin
                            if (w_can_emit) begin
                                w_emit            = 1'b1;
                                w_emit_val.status = ST_OVERFLOW;
                                n_leaf_exp        = 1'b0;
                                n_phase           = PH_DONE;
                                n_state           = S_FLUSH;
                            end
                        end else begin
                            w_nd_we    = 1'b1;
                            w_nd_sym   = w_is_leaf ? {1'b1, r_byte} : 9'd0;
                            n_is_leaf  = w_is_leaf;
                            n_leaf_exp = 1'b0;
                            n_state    = S_LINK;
                        end
                    end
                    PH_SEP: begin
                        n_walk  = '0;
                        n_phase = (r_rem != '0) ? PH_DECODE : PH_DONE;
                        n_state = S_FETCH;
                    end
                    PH_DECODE: begin
                        n_bit   = BIT_TOP;
                        n_state = S_DBIT;
                    end
                    default: begin
                        n_state = S_FETCH;
                    end
                endcase
            end
            S_LINK: begin
                n_popped = 1'b0;
                if (r_top != '0) begin
                    if (r_cache_ld) begin
                        w_right_we = 1'b1;
                        n_top      = r_top - 1'b1;
                        n_popped   = 1'b1;
                    end else begin
                        w_left_we   = 1'b1;
                        w_stk_we    = 1'b1;
                        w_stk_wdata = {1'b1, r_cache_idx};
                        n_cache_ld  = 1'b1;
                    end
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                n_next = r_next + 1'b1;
                if (!r_is_leaf) begin
                    w_stk_we    = 1'b1;
                    w_stk_waddr = r_top[SW-1:0];
                    w_stk_wdata = {1'b0, r_next[NW-1:0]};
                    n_cache_idx = r_next[NW-1:0];
                    n_cache_ld  = 1'b0;
                    n_top       = r_top + 1'b1;
                    n_state     = S_FETCH;
                end else if (r_top == '0) begin
                    n_phase = PH_SEP;
                    n_state = S_FETCH;
                end else if (r_popped) begin
                    n_state = S_RELOAD;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_RELOAD: begin
                n_cache_ld  = r_stk_q[NW];
                n_cache_idx = r_stk_q[NW-1:0];
                n_state     = S_FETCH;
            end
            S_DBIT: begin
                if (!r_sym_q[8]) begin
                    n_walk    = w_child;
                    w_nd_addr = w_child;
                end
                n_state = S_DCHK;
            end
            S_DCHK: begin
                if (r_sym_q[8]) begin
                    if (w_can_emit) begin
                        w_emit              = 1'b1;
                        w_emit_val.symbol   = r_sym_q[7:0];
                        w_emit_val.done_res = (r_rem == COUNT_BITS'(1));
                        n_rem               = r_rem - 1'b1;
                        n_walk              = '0;
                        w_nd_addr           = '0;
                        if (r_rem == COUNT_BITS'(1)) begin
                            n_phase = PH_DONE;
                            n_state = S_FLUSH;
                        end else if (r_bit == 3'd0) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_bit   = r_bit - 1'b1;
                            n_state = S_DBIT;
                        end
                    end
                end else if (r_bit == 3'd0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_DBIT;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_FETCH;
                end else if (!i_res_full) begin
                    w_flush  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_FETCH;
                end
            end
            default: begin
                n_state = S_FETCH;
            end
        endcase

        if (w_emit) begin
            n_pend_v = 1'b1;
            n_pend   = w_emit_val;
        end
    end

    assign o_res_push = w_flush || (w_emit && r_pend_v);

    always_comb begin
        o_res         = r_pend;
        o_res.run_end = w_flush;
    end

    always_ff @(posedge i_clk) begin
        if (w_nd_we) begin
            m_sym[r_next[NW-1:0]]   <= w_nd_sym;
            m_left[r_next[NW-1:0]]  <= '0;
            m_right[r_next[NW-1:0]] <= '0;
        end
        if (w_left_we) begin
            m_left[r_cache_idx] <= r_next[NW-1:0];
        end
        if (w_right_we) begin
            m_right[r_cache_idx] <= r_next[NW-1:0];
        end
        r_sym_q   <= m_sym[w_nd_addr];
        r_left_q  <= m_left[w_nd_addr];
        r_right_q <= m_right[w_nd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            m_stack[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_q <= m_stack[w_stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_phase     <= PH_HEADER;
            r_rem       <= '0;
            r_next      <= '0;
            r_top       <= '0;
            r_leaf_exp  <= 1'b0;
            r_walk      <= '0;
            r_pend_v    <= 1'b0;
            r_byte      <= '0;
            r_kind      <= '0;
            r_is_leaf   <= 1'b0;
            r_popped    <= 1'b0;
            r_cache_idx <= '0;
            r_cache_ld  <= 1'b0;
            r_bit       <= '0;
            r_pend      <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_next      <= n_next;
            r_top       <= n_top;
            r_leaf_exp  <= n_leaf_exp;
            r_walk      <= n_walk;
            r_pend_v    <= n_pend_v;
            r_byte      <= n_byte;
            r_kind      <= n_kind;
            r_is_leaf   <= n_is_leaf;
            r_popped    <= n_popped;
            r_cache_idx <= n_cache_idx;
            r_cache_ld  <= n_cache_ld;
            r_bit       <= n_bit;
            r_pend      <= n_pend;
        end
    end

endmodule

// ----- dv/huffman_stream_decoder_checker.sv -----
// Checker that predicts and compares the results of the stream decoder.
`timescale 1ns / 1ps
module huffman_stream_decoder_checker
    import huf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_symbol,
    input  logic       i_run_end,
    input  logic       i_done_res,
    input  logic [1:0] i_status,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_symbols,
    output int         o_bad_headers,
    output logic       o_in_decode
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TREE,
        PH_SEP,
        PH_DECODE,
        PH_DONE
    } t_phase;

    localparam int NODES = 512;
    localparam int STACK = 256;

    t_phase      phase;
    logic [39:0] remaining;
    logic [18:0] node_tbl [NODES];
    logic [9:0]  pend_stk [STACK];
    int          stk_top;
    int          next_node;
    logic        leaf_due;
    logic [8:0]  walk;
    t_result     symbol_q [$];

    assign o_pending   = symbol_q.size();
    assign o_in_decode = (phase == PH_DECODE);

    task automatic report(input string what);
        o_fail_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic add_result(input logic [7:0] sym, input logic done, input logic [1:0] st);
        t_result r;
        r.symbol   = sym;
        r.run_end  = 1'b0;
        r.done_res = done;
        r.status   = st;
        symbol_q.push_back(r);
    endtask

    task automatic tree_step(input logic [7:0] b);
        logic       is_leaf;
        logic       will_pop;
        int         eff;
        logic [9:0] ent;
        logic [8:0] par;
        if (!leaf_due && b == CH_ONE) begin
            leaf_due = 1'b1;
            return;
        end
        is_leaf  = leaf_due;
        leaf_due = 1'b0;
        will_pop = stk_top > 0 && pend_stk[stk_top-1][9];
        eff      = stk_top - (will_pop ? 1 : 0);
        if (next_node >= NODES || (!is_leaf && eff >= STACK)) begin
            add_result(8'd0, 1'b0, ST_OVERFLOW);
            phase = PH_DONE;
            return;
        end
        node_tbl[next_node] = is_leaf ? {1'b1, 10'd0, b} : 19'd0;
        if (stk_top > 0) begin
            ent = pend_stk[stk_top-1];
            par = ent[8:0];
            if (ent[9]) begin
                node_tbl[par][17:9] = next_node[8:0];
                stk_top--;
            end else begin
                node_tbl[par][8:0] = next_node[8:0];
                pend_stk[stk_top-1] = ent | 10'h200;
            end
        end
        if (!is_leaf) begin
            pend_stk[stk_top] = {1'b0, next_node[8:0]};
            stk_top++;
        end
        next_node++;
        if (stk_top == 0) phase = PH_SEP;
    endtask

    task automatic decode_step(input logic [7:0] b);
        logic [18:0] cur;
        for (int k = 7; k >= 0; k--) begin
            cur = node_tbl[walk];
            if (!cur[18]) begin
                walk = b[k] ? cur[17:9] : cur[8:0];
                cur  = node_tbl[walk];
            end
            if (cur[18]) begin
                remaining = remaining - 40'd1;
                walk      = '0;
                add_result(cur[7:0], remaining == 0, ST_SYMBOL);
                if (remaining == 0) begin
                    phase = PH_DONE;
                    break;
                end
            end
        end
    endtask

    task automatic predict_beat(input logic [7:0] b);
        int prior_size;
        prior_size = symbol_q.size();
        case (phase)
            PH_HEADER: begin
                if (b == CH_COMMA) begin
                    phase     = PH_TREE;
                    stk_top   = 0;
                    next_node = 0;
                    leaf_due  = 1'b0;
                    walk      = '0;
                end else if (b >= CH_ZERO && b < CH_ZERO + DIGITS) begin
                    remaining = remaining * 40'd10 + 40'(b - CH_ZERO);
                end else begin
                    add_result(8'd0, 1'b0, ST_BAD_HEADER);
                    o_bad_headers++;
                end
            end
            PH_TREE:   tree_step(b);
            PH_SEP: begin
                walk  = '0;
                phase = remaining != 0 ? PH_DECODE : PH_DONE;
            end
            PH_DECODE: decode_step(b);
            default: ;
        endcase
        if (symbol_q.size() > prior_size) symbol_q[$].run_end = 1'b1;
    endtask

    initial begin
        o_fail_count  = 0;
        o_symbols     = 0;
        o_bad_headers = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase     <= PH_HEADER;
            remaining <= '0;
            stk_top   <= 0;
            next_node <= 0;
            leaf_due  <= 1'b0;
            walk      <= '0;
        end else begin
            if (i_push && !i_full) predict_beat(i_in_byte);
            if (i_pop && !i_empty) begin
                if (symbol_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = symbol_q.pop_front();
                    if (want.status == ST_SYMBOL) o_symbols++;
                    if (i_symbol !== want.symbol)
                        report($sformatf("symbol %h, expected %h", i_symbol, want.symbol));
                    if (i_run_end !== want.run_end)
                        report($sformatf("run_end %b, expected %b", i_run_end, want.run_end));
                    if (i_done_res !== want.done_res)
                        report($sformatf("done_res %b, expected %b", i_done_res,
                                         want.done_res));
                    if (i_status !== want.status)
                        report($sformatf("status %0d, expected %0d", i_status, want.status));
                end
            end
        end
    end

endmodule

// ----- dv/huffman_stream_decoder_tb.sv -----
// Testbench top: builds one random compressed stream, drives it and gives the verdict.
`timescale 1ns / 1ps
module huffman_stream_decoder_tb;
    import huf_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_pop = 1'b0;
    logic       o_full, o_empty, o_run_end, o_done_res;
    logic [7:0] o_symbol;
    logic [1:0] o_status;
    int         fail_count, pending, symbols, bad_headers;
    logic       in_decode;
    logic [7:0] stream_q [$];
    int         leaves;
    bit         sent_all = 0;

    always #2 i_clk = ~i_clk;

    huffman_stream_decoder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_in_byte(i_in_byte), .o_empty(o_empty), .i_pop(i_pop), .o_symbol(o_symbol),
        .o_run_end(o_run_end), .o_done_res(o_done_res), .o_status(o_status)
    );

    huffman_stream_decoder_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_full(o_full),
        .i_in_byte(i_in_byte), .i_empty(o_empty), .i_pop(i_pop), .i_symbol(o_symbol),
        .i_run_end(o_run_end), .i_done_res(o_done_res), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending), .o_symbols(symbols),
        .o_bad_headers(bad_headers), .o_in_decode(in_decode)
    );

    function automatic logic [7:0] leaf_symbol();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return CH_ONE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] inner_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_ONE);
        return b;
    endfunction

    function automatic void add_subtree(int depth);
        if (depth >= 6 || leaves >= 24 || (depth > 0 && $urandom_range(0, 2) == 0)) begin
            stream_q.push_back(CH_ONE);
            stream_q.push_back(leaf_symbol());
            leaves++;
        end else begin
            stream_q.push_back(inner_byte());
            add_subtree(depth + 1);
            add_subtree(depth + 1);
        end
    endfunction

    function automatic void add_junk_header_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: do b = 8'($urandom);
                while (b == CH_COMMA || (b >= CH_ZERO && b < CH_ZERO + DIGITS));
        endcase
        stream_q.push_back(b);
    endfunction

    function automatic void build_stream();
        string digits;
        int    count;
        count = $urandom_range(150, 1400);
        // A 13-digit count past 2**40 checks that the count wraps.
        if ($urandom_range(0, 1)) digits = $sformatf("%0d", 64'd1099511627776 + count);
        else digits = $sformatf("%0d", count);
        add_junk_header_byte();
        add_junk_header_byte();
        for (int k = 0; k < digits.len(); k++) begin
            stream_q.push_back(digits[k]);
            if ($urandom_range(0, 3) == 0) add_junk_header_byte();
        end
        stream_q.push_back(CH_COMMA);
        leaves = 0;
        if ($urandom_range(0, 4) == 0) begin
            stream_q.push_back(CH_ONE);
            stream_q.push_back(leaf_symbol());
            leaves = 1;
        end else begin
            add_subtree(0);
        end
        stream_q.push_back(8'($urandom));
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        while (stream_q.size() < 260) stream_q.push_back(8'($urandom));
    endfunction

    initial begin
        int gap;
        bit burst;
        bit paused;
        build_stream();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst  = 0;
        paused = 0;
        foreach (stream_q[k]) begin
            if (!paused && (in_decode || k > stream_q.size() - 80)) begin
                i_push <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                paused = 1;
            end
            i_push    <= 1'b1;
            i_in_byte <= stream_q[k];
            @(posedge i_clk);
            while (o_full) @(posedge i_clk);
            if ($urandom_range(0, 15) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_push   <= 1'b0;
        sent_all = 1;
    end

    initial begin
        int beats;
        int gap;
        beats = 0;
        @(posedge i_rst_n);
        forever begin
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            beats++;
            gap = (beats % 50 < 10) ? 0 : $urandom_range(0, 5);
            if (beats == 40) gap = 400;
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        wait (sent_all);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Decoded %0d symbols from a %0d-leaf tree; %0d bad header bytes flagged.",
                 symbols, leaves, bad_headers);
        $display("Both sides stalled at random, with one long result stall and one drain.");
        if (fail_count == 0 && pending == 0) begin
            $display("huffman_stream_decoder_tb passed");
        end else begin
            $display("huffman_stream_decoder_tb failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("huffman_stream_decoder_tb failed");
        $finish;
    end

endmodule

// ----- huffman_stream_decoder.f -----
rtl/core/huf_pkg.sv
rtl/core/huf_front.sv
rtl/core/huf_out_fifo.sv
rtl/core/huf_engine.sv
rtl/core/huffman_stream_decoder.sv
dv/huffman_stream_decoder_checker.sv
dv/huffman_stream_decoder_tb.sv
